// ===== design/coh_pkg.sv =====
// shared constants, types and codes for the color occurrence histogram
// depends on nothing; used by coh_cell and color_occurrence_histogram
`default_nettype none
package coh_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COUNT_BITS  = 32;
    localparam int KEY_W       = 32;
    localparam int CHAN_W      = 8;
    localparam int OCC_W       = 32;
    localparam int TOTAL_W     = $clog2(TABLE_DEPTH + 1);

    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [TOTAL_W-1:0]    total_t;

    // command codes on the action port
    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_EMIT  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic cmp_en;   // compare held key against cell key
        logic upd_en;   // apply add result
        logic ins_en;   // no match and room left: insert with shift
        logic rot_en;   // rotate occupied cells toward cell 0
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/coh_cell.sv =====
// one table cell: holds a color key and its count, compares, shifts and rotates
// depends on coh_pkg
`default_nettype none
module coh_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire coh_pkg::cell_ctrl_t ctrl,
    input  wire logic                occupied,
    input  wire logic                next_occ,
    input  wire coh_pkg::key_t       new_key,
    input  wire coh_pkg::key_t       prev_key,
    input  wire coh_pkg::count_t     prev_count,
    input  wire logic                prev_lt,
    input  wire coh_pkg::key_t       next_key,
    input  wire coh_pkg::count_t     next_count,
    input  wire coh_pkg::key_t       wrap_key,
    input  wire coh_pkg::count_t     wrap_count,
    output coh_pkg::key_t            key,
    output coh_pkg::count_t          count,
    output logic                     lt,
    output logic                     eq
);

    coh_pkg::key_t   key_reg;
    coh_pkg::count_t count_reg;
    logic            lt_reg;
    logic            eq_reg;

    // compare flags, registered for the update cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            lt_reg <= occupied && (key_reg < new_key);
            eq_reg <= occupied && (key_reg == new_key);
        end
    end

    // entry payload: bump, insert, shift from the left neighbor, or rotate
    always_ff @(posedge clk)
    begin
        if (ctrl.upd_en)
        begin
            if (eq_reg)
            begin
                if (count_reg != '1)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (ctrl.ins_en)
            begin
                if (prev_lt && !lt_reg)
                begin
                    key_reg   <= new_key;
                    count_reg <= coh_pkg::count_t'(1);
                end
                else if (!prev_lt)
                begin
                    key_reg   <= prev_key;
                    count_reg <= prev_count;
                end
            end
        end
        else if (ctrl.rot_en)
        begin
            key_reg   <= next_occ ? next_key : wrap_key;
            count_reg <= next_occ ? next_count : wrap_count;
        end
    end

    assign key   = key_reg;
    assign count = count_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule
`default_nettype wire

// ===== design/color_occurrence_histogram.sv =====
// top level of the color occurrence histogram: command decode, cell chain, result register
// depends on coh_pkg and coh_cell
//
// usage
//   a command word (action, red, green, blue, alpha) is taken at a rising edge
//   with start high and busy low. add counts one pixel, emit reads the table,
//   clear empties the table and drops the overflow flag; action 3 does nothing.
//   the table is a chain of 64 cells kept in sorted color order.
//   add: a parallel compare in every cell, then an update cycle in which the
//   matching cell bumps its count, the cells right of the insert point shift
//   one place, or a full table sets the overflow flag; busy is high for the
//   compare cycle only, so a new command can be taken in the update cycle.
//   emit: the occupied cells rotate toward cell 0, one per cycle, and each
//   cell-0 word goes out registered with result_valid high for one cycle;
//   n entries give n words (an empty table gives one word), the first word
//   being the entry in cell 0 at the start, last_entry on the final one.
//   after the rotation the table is back in place.
//   results cannot be held off; the receiver takes each word in its cycle.
//   reset empties the table and clears the overflow flag; cell contents are
//   left as they were, since only cells below the entry count are ever read.
`default_nettype none
module color_occurrence_histogram (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  alpha,
    output logic             result_valid,
    output logic [7:0]       out_red,
    output logic [7:0]       out_green,
    output logic [7:0]       out_blue,
    output logic [7:0]       out_alpha,
    output logic [31:0]      occurrences,
    output logic [6:0]       distinct_total,
    output logic             overflowed,
    output logic             last_entry
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD,
        ST_EMIT
    } state_t;

    state_t                   state_reg;
    coh_pkg::key_t            key_reg;
    coh_pkg::total_t          total_reg;
    coh_pkg::total_t          emit_idx_reg;
    logic                     ovf_reg;
    logic                     res_valid_reg;
    coh_pkg::key_t            res_key_reg;
    coh_pkg::count_t          res_count_reg;
    coh_pkg::total_t          res_total_reg;
    logic                     res_ovf_reg;
    logic                     res_last_reg;

    coh_pkg::cell_ctrl_t      ctrl;
    coh_pkg::key_t            key_arr   [coh_pkg::TABLE_DEPTH];
    coh_pkg::count_t          count_arr [coh_pkg::TABLE_DEPTH];
    logic [coh_pkg::TABLE_DEPTH-1:0] lt_vec;
    logic [coh_pkg::TABLE_DEPTH-1:0] eq_vec;
    logic [coh_pkg::TABLE_DEPTH-1:0] occ_vec;

    logic accept;
    logic hit;
    logic full;
    logic do_insert;
    logic emit_done;

    assign busy   = (state_reg == ST_CMP) || (state_reg == ST_EMIT);
    assign accept = start && !busy;
    assign hit    = |eq_vec;
    assign full   = (total_reg == coh_pkg::total_t'(coh_pkg::TABLE_DEPTH));
    assign do_insert = (state_reg == ST_UPD) && !hit && !full;
    assign emit_done = (total_reg == '0) || (emit_idx_reg + 1'b1 == total_reg);

    // broadcast control to the chain
    always_comb
    begin
        ctrl.cmp_en = (state_reg == ST_CMP);
        ctrl.upd_en = (state_reg == ST_UPD);
        ctrl.ins_en = !hit && !full;
        ctrl.rot_en = (state_reg == ST_EMIT) && (total_reg != '0);
    end

    // cell chain
    for (genvar i = 0; i < coh_pkg::TABLE_DEPTH; i++)
    begin : g_cell
        coh_pkg::key_t   prev_key;
        coh_pkg::count_t prev_count;
        logic            prev_lt;
        coh_pkg::key_t   next_key;
        coh_pkg::count_t next_count;
        logic            next_occ;

        assign occ_vec[i] = (coh_pkg::total_t'(i) < total_reg);

        if (i == 0)
        begin : g_first
            assign prev_key   = '0;
            assign prev_count = '0;
            assign prev_lt    = 1'b1;
        end
        else
        begin : g_mid
            assign prev_key   = key_arr[i-1];
            assign prev_count = count_arr[i-1];
            assign prev_lt    = lt_vec[i-1];
        end

        if (i == coh_pkg::TABLE_DEPTH - 1)
        begin : g_end
            assign next_key   = key_arr[0];
            assign next_count = count_arr[0];
            assign next_occ   = 1'b0;
        end
        else
        begin : g_inner
            assign next_key   = key_arr[i+1];
            assign next_count = count_arr[i+1];
            assign next_occ   = occ_vec[i+1];
        end

        coh_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .occupied   (occ_vec[i]),
            .next_occ   (next_occ),
            .new_key    (key_reg),
            .prev_key   (prev_key),
            .prev_count (prev_count),
            .prev_lt    (prev_lt),
            .next_key   (next_key),
            .next_count (next_count),
            .wrap_key   (key_arr[0]),
            .wrap_count (count_arr[0]),
            .key        (key_arr[i]),
            .count      (count_arr[i]),
            .lt         (lt_vec[i]),
            .eq         (eq_vec[i])
        );
    end

    // held pixel key, loaded on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= {red, green, blue, alpha};
        end
    end

    // command sequencer, table count, flag and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            emit_idx_reg  <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            res_key_reg   <= '0;
            res_count_reg <= '0;
            res_total_reg <= '0;
            res_ovf_reg   <= 1'b0;
            res_last_reg  <= 1'b0;
        end
        else
        begin
            // a new command is taken in idle or in the update cycle
            if (accept)
            begin
                unique case (action)
                    coh_pkg::ACT_ADD:
                    begin
                        state_reg <= ST_CMP;
                    end
                    coh_pkg::ACT_EMIT:
                    begin
                        state_reg <= ST_EMIT;
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
            else
            begin
                unique case (state_reg)
                    ST_CMP:
                    begin
                        state_reg <= ST_UPD;
                    end
                    ST_EMIT:
                    begin
                        if (emit_done)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end

            // entry count and sticky overflow flag; a clear in the update
            // cycle wins over the add that finishes there
            if (accept && (action == coh_pkg::ACT_CLEAR))
            begin
                total_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (do_insert)
            begin
                total_reg <= total_reg + 1'b1;
            end
            else if ((state_reg == ST_UPD) && !hit)
            begin
                ovf_reg <= 1'b1;
            end

            // emit position
            if (accept)
            begin
                emit_idx_reg <= '0;
            end
            else if (state_reg == ST_EMIT)
            begin
                emit_idx_reg <= emit_idx_reg + 1'b1;
            end

            // result word, taken from cell 0 while the chain rotates
            res_valid_reg <= (state_reg == ST_EMIT);
            res_last_reg  <= (state_reg == ST_EMIT) && emit_done;
            if (state_reg == ST_EMIT)
            begin
                res_total_reg <= total_reg;
                res_ovf_reg   <= ovf_reg;
                res_key_reg   <= (total_reg == '0) ? '0 : key_arr[0];
                res_count_reg <= (total_reg == '0) ? '0 : count_arr[0];
            end
        end
    end

    // result ports
    assign result_valid   = res_valid_reg;
    assign out_red        = res_key_reg[31:24];
    assign out_green      = res_key_reg[23:16];
    assign out_blue       = res_key_reg[15:8];
    assign out_alpha      = res_key_reg[7:0];
    assign occurrences    = coh_pkg::OCC_W'(res_count_reg);
    assign distinct_total = res_total_reg;
    assign overflowed     = res_ovf_reg;
    assign last_entry     = res_last_reg;

    // checks
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EMIT))
        else $error("result word outside an emit run");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= coh_pkg::total_t'(coh_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_upd_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD |-> $past(state_reg == ST_CMP))
        else $error("update cycle without compare cycle");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_entry |-> result_valid)
        else $error("last marker without result word");

    a_ovf_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> total_reg == coh_pkg::total_t'(coh_pkg::TABLE_DEPTH))
        else $error("overflow raised while table had room");

    a_sorted_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) && occ_vec[1] |-> key_arr[0] < key_arr[1])
        else $error("first two entries out of order");

endmodule
`default_nettype wire
